FILE: rtl/scanline_seed_fill_engine_top_assert.svh
// assertion macros for the seed fill engine
`ifndef SCANLINE_SEED_FILL_ENGINE_TOP_ASSERT_SVH
`define SCANLINE_SEED_FILL_ENGINE_TOP_ASSERT_SVH
// consequent holds in the cycle after the antecedent
`define SSF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
// consequent holds in the same cycle as the antecedent
`define SSF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`endif

FILE: rtl/ssf_pkg.sv
// ------------------------------------------------------------------
// ssf_pkg
// types and constants shared by the seed fill engine
// ------------------------------------------------------------------
`default_nettype none
package ssf_pkg;
  localparam int ImageWidth  = 256;
  localparam int ImageHeight = 256;
  localparam int StackDepth  = 1024;
  localparam int XW  = 8;
  localparam int YW  = 8;
  localparam int AW  = XW + YW;
  localparam int SPW = $clog2(StackDepth);
  localparam int SCW = SPW + 1;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_FILL  = 2'd2;

  localparam logic [1:0] CLS_OTHER  = 2'd0;
  localparam logic [1:0] CLS_BOUND  = 2'd1;
  localparam logic [1:0] CLS_FILLED = 2'd2;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_OVF  = 2'd1;
  localparam logic [1:0] ST_OUTS = 2'd2;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] x_coord;
    logic [7:0] y_coord;
    logic [1:0] pixel_class;
  } in_word_t;

  typedef struct packed {
    logic [1:0] read_class;
    logic [1:0] status;
  } out_word_t;

  // frame store port request from the sequencer
  typedef struct packed {
    logic          rd;
    logic          wr;
    logic [AW-1:0] addr;
    logic [1:0]    wdata;
  } fs_req_t;

  function automatic logic is_clear(input logic [1:0] c);
    return (c != CLS_BOUND) && (c != CLS_FILLED);
  endfunction
endpackage
`default_nettype wire

FILE: rtl/ssf_frame_store.sv
// ------------------------------------------------------------------
// ssf_frame_store
// pixel class memory with clearing pass after reset
// ------------------------------------------------------------------
`default_nettype none
module ssf_frame_store
  import ssf_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  fs_req_t         req,
  output logic [1:0]      rdata,
  output logic            clr_busy
);
  logic [1:0]    mem [ImageWidth*ImageHeight];
  logic [AW:0]   clr_r, clr_nxt;

  assign clr_busy = !clr_r[AW];
  assign clr_nxt  = clr_busy ? clr_r + 1'b1 : clr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
    end else begin
      clr_r <= clr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (clr_busy) begin
      mem[clr_r[AW-1:0]] <= CLS_OTHER;
    end else if (req.wr) begin
      mem[req.addr] <= req.wdata;
    end
    if (req.rd) begin
      rdata <= mem[req.addr];
    end
  end
endmodule
`default_nettype wire

FILE: rtl/ssf_seed_stack.sv
// ------------------------------------------------------------------
// ssf_seed_stack
// seed memory, one push or one pop a cycle
// ------------------------------------------------------------------
`default_nettype none
module ssf_seed_stack
  import ssf_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          push,
  input  wire logic          pop,
  input  wire logic [SPW-1:0] addr,
  input  wire logic [AW-1:0] wdata,
  output logic [AW-1:0]      rdata
);
  logic [AW-1:0] mem [StackDepth];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[addr] <= wdata;
    end
    if (pop) begin
      rdata <= mem[addr];
    end
  end
endmodule
`default_nettype wire

FILE: rtl/scanline_seed_fill_engine_top.sv
// ------------------------------------------------------------------
// scanline_seed_fill_engine_top
// frame store of pixel classes with a scanline seed fill sequencer
// ------------------------------------------------------------------
// write/read: start, then S_ACC and S_DONE, then out_valid; busy meanwhile
// fill: each painted pixel and each scanned neighbor pixel takes a request
// and a wait state at the single frame store port; one word at a time
// after reset busy stays high while the store is cleared
// results cannot be stalled: out_valid lasts one cycle
`default_nettype none
module scanline_seed_fill_engine_top
  import ssf_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  output logic      busy,
  input  in_word_t  in_word,
  output logic      out_valid,
  output out_word_t out_word
);
  `include "scanline_seed_fill_engine_top_assert.svh"

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_ACC   = 4'd1;  // access: bounds check, read wait, write or first seed push
  localparam logic [3:0] S_DONE  = 4'd2;
  localparam logic [3:0] S_POP   = 4'd3;
  localparam logic [3:0] S_POPW  = 4'd4;
  localparam logic [3:0] S_RQ    = 4'd5;  // request pixel right
  localparam logic [3:0] S_RW    = 4'd6;
  localparam logic [3:0] S_LQ    = 4'd7;
  localparam logic [3:0] S_LW    = 4'd8;
  localparam logic [3:0] S_ROW   = 4'd9;  // pick row
  localparam logic [3:0] S_SQ    = 4'd10;
  localparam logic [3:0] S_SW    = 4'd11;
  localparam logic [3:0] S_SEED  = 4'd12;

  logic [3:0]     state_r, state_nxt;
  in_word_t       req_r, req_nxt;
  out_word_t      res_r, res_nxt;
  logic           ov_r, ov_nxt;
  logic [SCW-1:0] cnt_r, cnt_nxt;
  logic [XW-1:0]  sx_r, sx_nxt, xl_r, xl_nxt, xr_r, xr_nxt, cx_r, cx_nxt;
  logic [YW-1:0]  sy_r, sy_nxt, ry_r, ry_nxt;
  logic           lower_r, lower_nxt;  // scanning row below
  logic           prev_r, prev_nxt;    // previous scanned pixel clear
  logic [XW-1:0]  px_r, px_nxt;
  fs_req_t        fs;
  logic [1:0]     fs_rdata;
  logic           clr_busy;
  logic           st_push, st_pop;
  logic [SPW-1:0] st_addr;
  logic [AW-1:0]  st_wdata, st_rdata;
  logic           in_image;
  logic           do_push;
  logic [XW-1:0]  push_x;

  ssf_frame_store u_fs (.clk(clk), .rst_n(rst_n), .req(fs), .rdata(fs_rdata),
                        .clr_busy(clr_busy));
  ssf_seed_stack u_st (.clk(clk), .push(st_push), .pop(st_pop), .addr(st_addr),
                       .wdata(st_wdata), .rdata(st_rdata));

  assign busy      = (state_r != S_IDLE) || clr_busy;
  assign out_valid = ov_r;
  assign out_word  = res_r;
  assign in_image  = ({24'd0, req_r.x_coord} < ImageWidth) &&
                     ({24'd0, req_r.y_coord} < ImageHeight);

  always_comb begin
    state_nxt = state_r;
    req_nxt = req_r;
    res_nxt = res_r;
    ov_nxt = 1'b0;
    cnt_nxt = cnt_r;
    sx_nxt = sx_r; sy_nxt = sy_r; xl_nxt = xl_r; xr_nxt = xr_r; cx_nxt = cx_r;
    ry_nxt = ry_r; lower_nxt = lower_r; prev_nxt = prev_r; px_nxt = px_r;
    fs = '0;
    st_push = 1'b0; st_pop = 1'b0;
    st_addr = cnt_r[SPW-1:0];
    st_wdata = {sy_r, sx_r};
    do_push = 1'b0;
    push_x = px_r;
    unique case (state_r)
      S_IDLE: begin
        if (start && !clr_busy) begin
          req_nxt = in_word;
          state_nxt = S_ACC;
          res_nxt = '0;
          if (in_word.op == OP_READ) begin
            fs.rd = 1'b1;
            fs.addr = {in_word.y_coord, in_word.x_coord};
          end
        end
      end
      S_ACC: begin
        state_nxt = S_DONE;
        if (!in_image && (req_r.op == OP_WRITE || req_r.op == OP_READ ||
                          req_r.op == OP_FILL)) begin
          res_nxt.status = ST_OUTS;
        end else if (req_r.op == OP_WRITE) begin
          fs.wr = (req_r.pixel_class != 2'd3);
          fs.addr = {req_r.y_coord, req_r.x_coord};
          fs.wdata = req_r.pixel_class;
        end else if (req_r.op == OP_READ) begin
          res_nxt.read_class = fs_rdata;
        end else if (req_r.op == OP_FILL) begin
          st_push = 1'b1;
          st_addr = '0;
          st_wdata = {req_r.y_coord, req_r.x_coord};
          cnt_nxt = SCW'(1);
          state_nxt = S_POP;
        end
      end
      S_DONE: begin
        ov_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      S_POP: begin
        if (cnt_r == '0) begin
          state_nxt = S_DONE;
        end else begin
          st_pop = 1'b1;
          st_addr = SPW'(cnt_r - 1'b1);
          cnt_nxt = cnt_r - 1'b1;
          state_nxt = S_POPW;
        end
      end
      S_POPW: begin
        sx_nxt = st_rdata[XW-1:0];
        sy_nxt = st_rdata[AW-1:XW];
        fs.wr = 1'b1;
        fs.addr = st_rdata;
        fs.wdata = CLS_FILLED;
        xr_nxt = st_rdata[XW-1:0];
        xl_nxt = st_rdata[XW-1:0];
        state_nxt = S_RQ;
      end
      S_RQ: begin
        if ({24'd0, xr_r} + 32'd1 < ImageWidth) begin
          fs.rd = 1'b1;
          fs.addr = {sy_r, xr_r + 1'b1};
          state_nxt = S_RW;
        end else begin
          state_nxt = S_LQ;
        end
      end
      S_RW: begin
        if (fs_rdata != CLS_BOUND) begin
          xr_nxt = xr_r + 1'b1;
          fs.wr = 1'b1;
          fs.addr = {sy_r, xr_r + 1'b1};
          fs.wdata = CLS_FILLED;
          state_nxt = S_RQ;
        end else begin
          state_nxt = S_LQ;
        end
      end
      S_LQ: begin
        if (xl_r != '0) begin
          fs.rd = 1'b1;
          fs.addr = {sy_r, xl_r - 1'b1};
          state_nxt = S_LW;
        end else begin
          lower_nxt = 1'b0;
          state_nxt = S_ROW;
        end
      end
      S_LW: begin
        if (fs_rdata != CLS_BOUND) begin
          xl_nxt = xl_r - 1'b1;
          fs.wr = 1'b1;
          fs.addr = {sy_r, xl_r - 1'b1};
          fs.wdata = CLS_FILLED;
          state_nxt = S_LQ;
        end else begin
          lower_nxt = 1'b0;
          state_nxt = S_ROW;
        end
      end
      S_ROW: begin
        prev_nxt = 1'b0;
        cx_nxt = xl_r;
        if (!lower_r) begin
          ry_nxt = sy_r - 1'b1;
          if (sy_r != '0) state_nxt = S_SQ;
          else lower_nxt = 1'b1;
        end else begin
          ry_nxt = sy_r + 1'b1;
          if ({24'd0, sy_r} + 32'd1 < ImageHeight) state_nxt = S_SQ;
          else state_nxt = S_POP;
        end
      end
      S_SQ: begin
        fs.rd = 1'b1;
        fs.addr = {ry_r, cx_r};
        state_nxt = S_SW;
      end
      S_SW: begin
        // a clear run ends at a non-clear pixel or at the span end
        prev_nxt = is_clear(fs_rdata);
        px_nxt = cx_r;
        if (prev_r && !is_clear(fs_rdata)) begin
          do_push = 1'b1;
          push_x = px_r;
        end
        if (cx_r == xr_r) begin
          state_nxt = S_SEED;
        end else begin
          cx_nxt = cx_r + 1'b1;
          state_nxt = S_SQ;
        end
      end
      S_SEED: begin
        if (prev_r) begin
          do_push = 1'b1;
          push_x = px_r;
        end
        state_nxt = lower_r ? S_POP : S_ROW;
        lower_nxt = 1'b1;
      end
      default: state_nxt = S_IDLE;
    endcase
    if (do_push) begin
      if ({{(32-SCW){1'b0}}, cnt_r} >= StackDepth) begin
        res_nxt.status = ST_OVF;
        state_nxt = S_DONE;
      end else begin
        st_push = 1'b1;
        st_addr = cnt_r[SPW-1:0];
        st_wdata = {ry_r, push_x};
        cnt_nxt = cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r    <= 1'b0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r <= req_nxt; res_r <= res_nxt;
    sx_r <= sx_nxt; sy_r <= sy_nxt; xl_r <= xl_nxt; xr_r <= xr_nxt;
    cx_r <= cx_nxt; ry_r <= ry_nxt; lower_r <= lower_nxt;
    prev_r <= prev_nxt; px_r <= px_nxt;
  end

  `SSF_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy)
  `SSF_ASSERT_NOW(a_valid_not_idle_start, clk, rst_n, out_valid, state_r == S_IDLE)
  `SSF_ASSERT_NOW(a_no_cnt_overrun, clk, rst_n, 1'b1,
                  {{(32-SCW){1'b0}}, cnt_r} <= StackDepth)
endmodule
`default_nettype wire

FILE: tb/testbench.sv
// ------------------------------------------------------------------
// scanline seed fill engine testbench
// drives pixel writes, reads and seed fills through the start/busy port,
// keeps a shadow frame store with its own fill walk, and checks every
// result word against it
// ------------------------------------------------------------------
`default_nettype none
module testbench;
  import ssf_pkg::*;

  localparam logic [1:0] OP_UNUSED   = 2'd3;
  localparam logic [1:0] CLS_INVALID = 2'd3;
  localparam int         ItemTarget  = 1450;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  in_word_t  in_word = '0;
  logic      busy;
  logic      out_valid;
  out_word_t out_word;

  always #10 clk = ~clk;

  scanline_seed_fill_engine_top dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_word(in_word), .out_valid(out_valid), .out_word(out_word)
  );

  logic [1:0]    shadow_frame [ImageWidth*ImageHeight];
  logic [AW-1:0] shadow_seeds [StackDepth];
  int            shadow_seed_count;
  out_word_t     expected_words [$];
  bit            failed = 1'b0;
  int            items_sent = 0;
  int            calm_left = 0;

  function automatic bit pixel_open(int x, int y);
    logic [1:0] c;
    c = shadow_frame[y*ImageWidth + x];
    return (c != CLS_BOUND) && (c != CLS_FILLED);
  endfunction

  function automatic bit push_shadow_seed(int x, int y);
    if (shadow_seed_count >= StackDepth) return 1'b0;
    shadow_seeds[shadow_seed_count] = {y[YW-1:0], x[XW-1:0]};
    shadow_seed_count++;
    return 1'b1;
  endfunction

  // rightmost clear pixel of each clear run in xl..xr
  function automatic bit scan_row_seeds(int xl, int xr, int y);
    for (int x = xl; x <= xr; x++) begin
      if (pixel_open(x, y) && (x == xr || !pixel_open(x + 1, y))) begin
        if (!push_shadow_seed(x, y)) return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  function automatic logic [1:0] shadow_seed_fill(int sx, int sy);
    int x, y, xl, xr;
    shadow_seed_count = 0;
    void'(push_shadow_seed(sx, sy));
    while (shadow_seed_count > 0) begin
      shadow_seed_count--;
      x = shadow_seeds[shadow_seed_count][XW-1:0];
      y = shadow_seeds[shadow_seed_count][AW-1:XW];
      shadow_frame[y*ImageWidth + x] = CLS_FILLED;
      xr = x;
      while (xr + 1 < ImageWidth && shadow_frame[y*ImageWidth + xr + 1] != CLS_BOUND) begin
        xr++;
        shadow_frame[y*ImageWidth + xr] = CLS_FILLED;
      end
      xl = x;
      while (xl > 0 && shadow_frame[y*ImageWidth + xl - 1] != CLS_BOUND) begin
        xl--;
        shadow_frame[y*ImageWidth + xl] = CLS_FILLED;
      end
      if (y > 0 && !scan_row_seeds(xl, xr, y - 1)) return ST_OVF;
      if (y + 1 < ImageHeight && !scan_row_seeds(xl, xr, y + 1)) return ST_OVF;
    end
    return ST_OK;
  endfunction

  function automatic out_word_t shadow_result(in_word_t w);
    out_word_t r;
    bit in_image;
    int x, y;
    r = '0;
    x = w.x_coord;
    y = w.y_coord;
    in_image = (x < ImageWidth) && (y < ImageHeight);
    case (w.op)
      OP_WRITE: begin
        if (!in_image) r.status = ST_OUTS;
        else if (w.pixel_class != CLS_INVALID) shadow_frame[y*ImageWidth + x] = w.pixel_class;
      end
      OP_READ: begin
        if (!in_image) r.status = ST_OUTS;
        else r.read_class = shadow_frame[y*ImageWidth + x];
      end
      OP_FILL: begin
        if (!in_image) r.status = ST_OUTS;
        else r.status = shadow_seed_fill(x, y);
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_words.size() == 0) begin
        $error("result word with nothing expected: read_class %0d status %0d",
               out_word.read_class, out_word.status);
        failed = 1'b1;
      end else begin
        if (out_word.read_class !== expected_words[0].read_class) begin
          $error("read_class expected %0d actual %0d",
                 expected_words[0].read_class, out_word.read_class);
          failed = 1'b1;
        end
        if (out_word.status !== expected_words[0].status) begin
          $error("status expected %0d actual %0d",
                 expected_words[0].status, out_word.status);
          failed = 1'b1;
        end
        void'(expected_words.pop_front());
      end
    end
  end

  task automatic send_word(input logic [1:0] op, input int x, input int y,
                           input logic [1:0] cls);
    in_word_t w;
    int gap;
    w.op = op;
    w.x_coord = x[7:0];
    w.y_coord = y[7:0];
    w.pixel_class = cls;
    if (calm_left > 0) begin
      gap = 0;
      calm_left--;
    end else begin
      gap = $urandom_range(0, 13);
      if ($urandom_range(0, 19) == 0) calm_left = $urandom_range(10, 40);
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_word <= w;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    expected_words = {expected_words, shadow_result(w)};
    items_sent++;
  endtask

  // walls around interior xa..xb, ya..yb, clipped at the image edge
  task automatic draw_box(input int xa, input int xb, input int ya, input int yb);
    for (int x = xa - 1; x <= xb + 1; x++) begin
      if (x >= 0 && x < ImageWidth) begin
        if (ya > 0) send_word(OP_WRITE, x, ya - 1, CLS_BOUND);
        if (yb < ImageHeight - 1) send_word(OP_WRITE, x, yb + 1, CLS_BOUND);
      end
    end
    for (int y = ya; y <= yb; y++) begin
      if (xa > 0) send_word(OP_WRITE, xa - 1, y, CLS_BOUND);
      if (xb < ImageWidth - 1) send_word(OP_WRITE, xb + 1, y, CLS_BOUND);
    end
  endtask

  task automatic test_pixel_access;
    send_word(OP_READ, 0, 0, CLS_OTHER);
    send_word(OP_WRITE, 0, 0, CLS_BOUND);
    send_word(OP_WRITE, 255, 255, CLS_FILLED);
    send_word(OP_WRITE, 0, 0, CLS_INVALID);
    send_word(OP_READ, 0, 0, CLS_INVALID);
    send_word(OP_READ, 255, 255, CLS_OTHER);
    send_word(OP_WRITE, 255, 0, CLS_OTHER);
    send_word(OP_READ, 255, 0, CLS_FILLED);
    send_word(OP_UNUSED, 0, 255, CLS_FILLED);
    send_word(OP_UNUSED, 255, 255, CLS_INVALID);
  endtask

  // patterned rows give one seed per clear pixel and run the stack over
  task automatic test_stack_overflow;
    for (int y = 1; y < 20; y += 2)
      for (int x = 0; x < ImageWidth; x += 2)
        send_word(OP_WRITE, x, y, CLS_BOUND);
    // seed in the open part of the top row, clear of the corner box
    send_word(OP_FILL, 128, 0, CLS_OTHER);
  endtask

  task automatic test_edge_fills;
    draw_box(0, 2, 0, 2);
    send_word(OP_FILL, 1, 1, CLS_OTHER);
    send_word(OP_READ, 0, 0, CLS_OTHER);
    draw_box(253, 255, 253, 255);
    send_word(OP_WRITE, 254, 254, CLS_OTHER);
    send_word(OP_FILL, 255, 255, CLS_OTHER);
    send_word(OP_READ, 253, 253, CLS_OTHER);
    // seed on a boundary pixel inside a closed box
    draw_box(100, 103, 100, 101);
    send_word(OP_WRITE, 101, 100, CLS_BOUND);
    send_word(OP_FILL, 101, 100, CLS_OTHER);
    send_word(OP_READ, 101, 100, CLS_OTHER);
  endtask

  task automatic test_random;
    int xa, xb, ya, yb, n;
    logic [1:0] op;
    while (items_sent < ItemTarget) begin
      if ($urandom_range(0, 2) != 0) begin
        xa = $urandom_range(0, 255);
        ya = $urandom_range(0, 255);
        xb = xa + $urandom_range(0, 4);
        yb = ya + $urandom_range(0, 4);
        if (xb > 255) xb = 255;
        if (yb > 255) yb = 255;
        draw_box(xa, xb, ya, yb);
        for (int y = ya; y <= yb; y++)
          for (int x = xa; x <= xb; x++)
            send_word(OP_WRITE, x, y,
                      ($urandom_range(0, 3) == 0) ? 2'($urandom_range(0, 3)) : CLS_OTHER);
        send_word(OP_FILL, $urandom_range(xa, xb), $urandom_range(ya, yb),
                  2'($urandom_range(0, 3)));
        send_word(OP_READ, $urandom_range(xa, xb), $urandom_range(ya, yb), CLS_OTHER);
      end else begin
        n = $urandom_range(1, 8);
        repeat (n) begin
          case ($urandom_range(0, 4))
            0, 1:    op = OP_WRITE;
            2, 3:    op = OP_READ;
            default: op = OP_UNUSED;
          endcase
          send_word(op, $urandom_range(0, 255), $urandom_range(0, 255),
                    2'($urandom_range(0, 3)));
        end
      end
    end
  endtask

  initial begin
    for (int i = 0; i < ImageWidth*ImageHeight; i++) shadow_frame[i] = CLS_OTHER;
    shadow_seed_count = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_pixel_access;
    test_edge_fills;
    test_stack_overflow;
    test_random;
    start <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (!failed) begin
      $display("scanline_seed_fill_engine_top test passed");
    end else begin
      $display("scanline_seed_fill_engine_top test failed");
    end
    $finish;
  end

  initial begin
    #(64'd200_000_000);
    $display("scanline_seed_fill_engine_top test failed");
    $finish;
  end
endmodule
`default_nettype wire
